FILE: hw/rtl/gvt_pkg.sv
// Shared types, constants and helpers for the grid voxel traversal core.
// Used by gvt_arith and grid_voxel_traversal_core; no dependencies.
package gvt_pkg;

    localparam int MAX_CELLS  = 64;
    localparam int CELL_W     = 6;
    localparam int CNT_W      = 7;
    localparam int SIZE_W     = 31;
    localparam int COORD_W    = 32;
    localparam int DIR_W      = 16;
    localparam int T_W        = 32;
    localparam int WIDE_W     = 64;
    localparam int DIVISOR_W  = 32;
    localparam int DIR_FRAC   = 14;
    localparam int EXT_W      = CNT_W + SIZE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 3 * COORD_W + 3 * DIR_W;
    localparam int OUT_DATA_W = 56;
    localparam int STAT_W     = 2;
    localparam int ITER_W     = 6;

    localparam logic [T_W-1:0] T_SAT = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXT,
        ST_SLAB_A,
        ST_SLAB_B,
        ST_SLAB_CHK,
        ST_ENTRY,
        ST_CELL,
        ST_BD,
        ST_NB,
        ST_ADV,
        ST_FIN
    } state_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSIDE = 2'd0,
        STAT_MISS   = 2'd1,
        STAT_LEFT   = 2'd2
    } status_t;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X  = 3'd0,
        CFG_SIZE_Y  = 3'd1,
        CFG_SIZE_Z  = 3'd2,
        CFG_CELLS_X = 3'd3,
        CFG_CELLS_Y = 3'd4,
        CFG_CELLS_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                 start;
        op_t                  op;
        logic [WIDE_W-1:0]    opa;
        logic [DIVISOR_W-1:0] opb;
    } arith_req_t;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] result;
    } arith_rsp_t;

    function automatic logic [T_W-1:0] sat_t32(input logic [WIDE_W-1:0] v);
        sat_t32 = (|v[WIDE_W-1:T_W]) ? T_SAT : v[T_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        eff_size = (s == '0) ? SIZE_W'(1) : s;
    endfunction

    function automatic logic [CNT_W-1:0] eff_cells(input logic [CNT_W-1:0] n);
        if (n == '0)
            eff_cells = CNT_W'(1);
        else if (n > CNT_W'(MAX_CELLS))
            eff_cells = CNT_W'(MAX_CELLS);
        else
            eff_cells = n;
    endfunction

    function automatic logic [T_W-1:0] min3(input logic [T_W-1:0] a,
                                            input logic [T_W-1:0] b,
                                            input logic [T_W-1:0] c);
        logic [T_W-1:0] m;
        m = a;
        if (b < m)
            m = b;
        if (c < m)
            m = c;
        min3 = m;
    endfunction

endpackage

FILE: hw/rtl/gvt_arith.sv
// Shared bit-serial arithmetic unit: 64/32 restoring divide and 64x16
// shift-add multiply. Depends on gvt_pkg.
module gvt_arith (
    input  logic                aclk,
    input  logic                aresetn,
    input  gvt_pkg::arith_req_t req,
    output gvt_pkg::arith_rsp_t rsp
);
    import gvt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    op_t                  op_reg, op_next;
    logic [ITER_W-1:0]    cnt_reg, cnt_next;
    logic [WIDE_W-1:0]    acc_reg, acc_next;
    logic [WIDE_W-1:0]    a_reg, a_next;
    logic [DIVISOR_W-1:0] b_reg, b_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W:0]   sh;
    logic                 ge;

    assign sh = {rem_reg, a_reg[WIDE_W-1]};
    assign ge = sh >= {1'b0, b_reg};

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        done_next = busy_reg && (cnt_reg == '0);
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = (req.op == OP_DIV) ? ITER_W'(WIDE_W - 1) : ITER_W'(DIR_W - 1);
            acc_next  = '0;
            a_next    = req.opa;
            b_next    = req.opb;
            rem_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == '0)
                busy_next = 1'b0;
            a_next = {a_reg[WIDE_W-2:0], 1'b0};
            case (op_reg)
                OP_DIV: begin
                    rem_next = ge ? DIVISOR_W'(sh - {1'b0, b_reg}) : sh[DIVISOR_W-1:0];
                    acc_next = {acc_reg[WIDE_W-2:0], ge};
                end
                OP_MUL: begin
                    acc_next = b_reg[0] ? acc_reg + a_reg : acc_reg;
                    b_next   = {1'b0, b_reg[DIVISOR_W-1:1]};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

FILE: hw/rtl/grid_voxel_traversal_core.sv
// Grid voxel traversal core: 3D DDA ray walk through a uniform voxel grid.
// Depends on gvt_pkg and gvt_arith.
//
// Usage:
//  - cfg_we/cfg_index/cfg_wdata write cell sizes (0..2) and cell counts
//    (3..5); write only while the core is idle.
//  - s_axis carries one word per request: tuser 0 starts a ray, 1 advances
//    one cell. m_axis returns exactly one word per request.
//  - An advance passes from idle into ST_ADV, which loads its result into
//    the output register once that is free; then the core is idle again.
//  - A start is shortest for a miss found without any divide, and longest
//    with up to fifteen divides and three multiplies, each with an issue
//    and a handoff step, all run in series on one shared bit-serial unit.
//  - s_axis_tready is high only while the sequencer is idle; one request
//    is in flight at a time.
//  - A finished word sits in the output register; the next request can be
//    accepted meanwhile, and its result waits until m_axis_tready drains it.
//  - Reset (aresetn low, synchronous) restores default config and drops
//    any active ray.
module grid_voxel_traversal_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [gvt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gvt_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [gvt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cell_x, cell_y, cell_z, exit_t, zero pad
    output logic [gvt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [gvt_pkg::STAT_W-1:0]        m_axis_tuser
);
    import gvt_pkg::*;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] cfg_size_reg [3];
    logic [CNT_W-1:0]  cfg_cells_reg [3];

    logic signed [COORD_W-1:0] o_reg [3], o_next [3];
    logic signed [DIR_W-1:0]   d_reg [3], d_next [3];
    logic [EXT_W-1:0]          ext_reg [3], ext_next [3];
    logic signed [WIDE_W-1:0]  p_reg [3], p_next [3];
    logic [CELL_W-1:0]         cur_reg [3], cur_next [3];
    logic [T_W-1:0]            nb_reg [3], nb_next [3];
    logic [T_W-1:0]            bd_reg [3], bd_next [3];
    logic                      neg_reg [3], neg_next [3];
    logic                      walk_reg, walk_next;

    logic [1:0]               ax_reg, ax_next;
    logic                     issued_reg, issued_next;
    logic                     inside_reg, inside_next;
    logic                     miss_reg, miss_next;
    logic signed [WIDE_W-1:0] tn_reg, tn_next, tf_reg, tf_next;
    logic signed [WIDE_W-1:0] sa_reg, sa_next, tt_reg, tt_next;

    logic                 mv_reg, mv_next;
    status_t              ms_reg, ms_next;
    logic [CELL_W-1:0]    mc_reg [3], mc_next [3];
    logic [T_W-1:0]       mt_reg, mt_next;

    arith_req_t req;
    arith_rsp_t rsp;

    gvt_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // axis-selected operands
    logic [SIZE_W-1:0]        cs_sel;
    logic [CNT_W-1:0]         n_sel;
    logic signed [COORD_W-1:0] o_sel;
    logic signed [DIR_W-1:0]  d_sel;
    logic signed [WIDE_W-1:0] o64, ext64, prod64, slab_num, nb_num, sq, q_mul;
    logic [DIR_W-1:0]         d_abs;
    logic [CNT_W-1:0]         mul_cnt;
    logic [EXT_W-1:0]         prod_small;
    logic                     d_zero, d_pos, last_ax, accept, out_free;
    logic                     need_op, phase_done, outside_now, chk_fail;
    logic [WIDE_W-1:0]        slab_abs;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !mv_reg || m_axis_tready;

    assign cs_sel  = eff_size(cfg_size_reg[ax_reg]);
    assign n_sel   = eff_cells(cfg_cells_reg[ax_reg]);
    assign o_sel   = o_reg[ax_reg];
    assign d_sel   = d_reg[ax_reg];
    assign d_zero  = (d_sel == '0);
    assign d_pos   = !d_sel[DIR_W-1] && !d_zero;
    assign d_abs   = d_sel[DIR_W-1] ? DIR_W'(-d_sel) : d_sel;
    assign last_ax = (ax_reg == 2'd2);

    assign mul_cnt = (state_reg == ST_NB) ?
                     (d_pos ? CNT_W'({1'b0, cur_reg[ax_reg]}) + CNT_W'(1)
                            : CNT_W'({1'b0, cur_reg[ax_reg]})) : n_sel;
    assign prod_small = EXT_W'(mul_cnt) * EXT_W'(cs_sel);

    assign o64    = {{(WIDE_W-COORD_W){o_sel[COORD_W-1]}}, o_sel};
    assign ext64  = $signed({{(WIDE_W-EXT_W){1'b0}}, ext_reg[ax_reg]});
    assign prod64 = $signed({{(WIDE_W-EXT_W){1'b0}}, prod_small});

    assign outside_now = o_sel[COORD_W-1] ||
                         (o64 > $signed({{(WIDE_W-EXT_W){1'b0}}, prod_small}));

    assign slab_num = ((state_reg == ST_SLAB_A) ? -o64 : (ext64 - o64)) <<< DIR_FRAC;
    assign slab_abs = slab_num[WIDE_W-1] ? WIDE_W'(-slab_num) : slab_num;
    assign sq       = (slab_num[WIDE_W-1] ^ d_sel[DIR_W-1]) ?
                      -$signed(rsp.result) : $signed(rsp.result);
    assign nb_num   = d_pos ? (prod64 - o64) : (o64 - prod64);
    assign q_mul    = d_sel[DIR_W-1] ? -$signed(rsp.result) : $signed(rsp.result);
    assign chk_fail = miss_reg || (tn_reg > tf_reg) || tf_reg[WIDE_W-1];

    always_comb begin
        case (state_reg)
            ST_SLAB_A: need_op = !d_zero;
            ST_SLAB_B: need_op = 1'b1;
            ST_ENTRY:  need_op = 1'b1;
            ST_CELL:   need_op = !p_reg[ax_reg][WIDE_W-1];
            ST_BD:     need_op = !d_zero;
            ST_NB:     need_op = !nb_num[WIDE_W-1];
            default:   need_op = 1'b0;
        endcase
        phase_done = !need_op || (issued_reg && rsp.done);
    end

    always_comb begin
        req.start = need_op && !issued_reg;
        req.op    = (state_reg == ST_ENTRY) ? OP_MUL : OP_DIV;
        req.opb   = DIVISOR_W'(d_abs);
        case (state_reg)
            ST_ENTRY: req.opa = tt_reg;
            ST_CELL: begin
                req.opa = p_reg[ax_reg];
                req.opb = DIVISOR_W'(cs_sel);
            end
            ST_BD:    req.opa = WIDE_W'(cs_sel) << DIR_FRAC;
            ST_NB:    req.opa = nb_num <<< DIR_FRAC;
            default:  req.opa = slab_abs;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = s_axis_tuser ? ST_ADV : ST_EXT;
            ST_EXT:
                if (last_ax)
                    state_next = (inside_reg && !outside_now) ? ST_CELL : ST_SLAB_A;
            ST_SLAB_A:
                if (phase_done)
                    state_next = !d_zero ? ST_SLAB_B : (last_ax ? ST_SLAB_CHK : ST_SLAB_A);
            ST_SLAB_B:
                if (phase_done)
                    state_next = last_ax ? ST_SLAB_CHK : ST_SLAB_A;
            ST_SLAB_CHK:
                state_next = chk_fail ? ST_FIN : ST_ENTRY;
            ST_ENTRY:
                if (phase_done && last_ax)
                    state_next = ST_CELL;
            ST_CELL:
                if (phase_done)
                    state_next = ST_BD;
            ST_BD:
                if (phase_done)
                    state_next = !d_zero ? ST_NB : (last_ax ? ST_FIN : ST_CELL);
            ST_NB:
                if (phase_done)
                    state_next = last_ax ? ST_FIN : ST_CELL;
            ST_ADV, ST_FIN:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // advance step
    logic [1:0]        k;
    logic [T_W-1:0]    t_k;
    logic [CELL_W-1:0] c_k, nc_k;
    logic              leave;
    logic [T_W:0]      sum_k;
    logic [T_W-1:0]    nb_adv [3];

    always_comb begin
        k = 2'd0;
        if (nb_reg[1] < nb_reg[0])
            k = 2'd1;
        if (nb_reg[2] < nb_reg[k])
            k = 2'd2;
        t_k   = nb_reg[k];
        c_k   = cur_reg[k];
        nc_k  = neg_reg[k] ? c_k - CELL_W'(1) : c_k + CELL_W'(1);
        leave = (t_k == T_SAT) ||
                (neg_reg[k] ? ((c_k == '0) ||
                               (CNT_W'({1'b0, c_k}) > eff_cells(cfg_cells_reg[k])))
                            : (CNT_W'({1'b0, c_k}) + CNT_W'(1) >= eff_cells(cfg_cells_reg[k])));
        sum_k = {1'b0, t_k} + {1'b0, bd_reg[k]};
        for (int i = 0; i < 3; i++)
            nb_adv[i] = nb_reg[i];
        nb_adv[k] = sum_k[T_W] ? T_SAT : sum_k[T_W-1:0];
    end

    // datapath
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_next[i]   = o_reg[i];
            d_next[i]   = d_reg[i];
            ext_next[i] = ext_reg[i];
            p_next[i]   = p_reg[i];
            cur_next[i] = cur_reg[i];
            nb_next[i]  = nb_reg[i];
            bd_next[i]  = bd_reg[i];
            neg_next[i] = neg_reg[i];
            mc_next[i]  = mc_reg[i];
        end
        walk_next   = walk_reg;
        ax_next     = ax_reg;
        issued_next = req.start ? 1'b1 : (rsp.done ? 1'b0 : issued_reg);
        inside_next = inside_reg;
        miss_next   = miss_reg;
        tn_next     = tn_reg;
        tf_next     = tf_reg;
        sa_next     = sa_reg;
        tt_next     = tt_reg;
        mv_next     = (mv_reg && !m_axis_tready);
        ms_next     = ms_reg;
        mt_next     = mt_reg;

        if (phase_done && ((state_reg == ST_EXT) || (state_reg == ST_SLAB_B) ||
                           (state_reg == ST_ENTRY) || (state_reg == ST_NB) ||
                           (((state_reg == ST_SLAB_A) || (state_reg == ST_BD)) && d_zero)))
            ax_next = last_ax ? 2'd0 : ax_reg + 2'd1;

        case (state_reg)
            ST_IDLE:
                if (accept) begin
                    for (int i = 0; i < 3; i++) begin
                        o_next[i] = s_axis_tdata[i*COORD_W +: COORD_W];
                        d_next[i] = s_axis_tdata[3*COORD_W + i*DIR_W +: DIR_W];
                    end
                    ax_next     = 2'd0;
                    inside_next = 1'b1;
                    miss_next   = 1'b0;
                    tn_next     = {1'b1, {(WIDE_W-1){1'b0}}};
                    tf_next     = {1'b0, {(WIDE_W-1){1'b1}}};
                end
            ST_EXT: begin
                ext_next[ax_reg] = prod_small;
                p_next[ax_reg]   = o64;
                if (outside_now)
                    inside_next = 1'b0;
            end
            ST_SLAB_A:
                if (d_zero) begin
                    if (o_sel[COORD_W-1] || (o64 > ext64))
                        miss_next = 1'b1;
                end else if (phase_done) begin
                    sa_next = sq;
                end
            ST_SLAB_B:
                if (phase_done) begin
                    if (((sa_reg < sq) ? sa_reg : sq) > tn_reg)
                        tn_next = (sa_reg < sq) ? sa_reg : sq;
                    if (((sa_reg < sq) ? sq : sa_reg) < tf_reg)
                        tf_next = (sa_reg < sq) ? sq : sa_reg;
                end
            ST_SLAB_CHK:
                tt_next = tn_reg[WIDE_W-1] ? '0 : tn_reg;
            ST_ENTRY:
                if (phase_done)
                    p_next[ax_reg] = o64 + (q_mul >>> DIR_FRAC);
            ST_CELL:
                if (p_reg[ax_reg][WIDE_W-1])
                    cur_next[ax_reg] = '0;
                else if (phase_done)
                    cur_next[ax_reg] = (rsp.result > WIDE_W'(n_sel - CNT_W'(1))) ?
                                       CELL_W'(n_sel - CNT_W'(1)) : rsp.result[CELL_W-1:0];
            ST_BD:
                if (d_zero) begin
                    bd_next[ax_reg]  = T_SAT;
                    nb_next[ax_reg]  = T_SAT;
                    neg_next[ax_reg] = 1'b1;
                end else if (phase_done) begin
                    bd_next[ax_reg]  = sat_t32(rsp.result);
                    neg_next[ax_reg] = d_sel[DIR_W-1];
                end
            ST_NB:
                if (nb_num[WIDE_W-1])
                    nb_next[ax_reg] = '0;
                else if (phase_done)
                    nb_next[ax_reg] = sat_t32(rsp.result);
            ST_ADV:
                if (out_free) begin
                    mv_next = 1'b1;
                    ms_next = STAT_LEFT;
                    for (int i = 0; i < 3; i++)
                        mc_next[i] = cur_reg[i];
                    if (!walk_reg) begin
                        mt_next = '0;
                    end else if (leave) begin
                        walk_next = 1'b0;
                        mt_next   = t_k;
                    end else begin
                        cur_next[k] = nc_k;
                        mc_next[k]  = nc_k;
                        nb_next[k]  = nb_adv[k];
                        ms_next     = STAT_INSIDE;
                        mt_next     = min3(nb_adv[0], nb_adv[1], nb_adv[2]);
                    end
                end
            ST_FIN:
                if (out_free) begin
                    mv_next = 1'b1;
                    if (miss_reg || !inside_reg && chk_fail) begin
                        walk_next = 1'b0;
                        ms_next   = STAT_MISS;
                        mt_next   = '0;
                        for (int i = 0; i < 3; i++)
                            mc_next[i] = '0;
                    end else begin
                        walk_next = 1'b1;
                        ms_next   = STAT_INSIDE;
                        mt_next   = min3(nb_reg[0], nb_reg[1], nb_reg[2]);
                        for (int i = 0; i < 3; i++)
                            mc_next[i] = cur_reg[i];
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            walk_reg   <= 1'b0;
            issued_reg <= 1'b0;
            mv_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                cfg_size_reg[i]  <= SIZE_W'(65536);
                cfg_cells_reg[i] <= CNT_W'(MAX_CELLS);
                cur_reg[i]       <= '0;
                nb_reg[i]        <= T_SAT;
                bd_reg[i]        <= T_SAT;
                neg_reg[i]       <= 1'b0;
            end
        end else begin
            state_reg  <= state_next;
            walk_reg   <= walk_next;
            issued_reg <= issued_next;
            mv_reg     <= mv_next;
            for (int i = 0; i < 3; i++) begin
                cur_reg[i] <= cur_next[i];
                nb_reg[i]  <= nb_next[i];
                bd_reg[i]  <= bd_next[i];
                neg_reg[i] <= neg_next[i];
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SIZE_X:  cfg_size_reg[0]  <= cfg_wdata;
                    CFG_SIZE_Y:  cfg_size_reg[1]  <= cfg_wdata;
                    CFG_SIZE_Z:  cfg_size_reg[2]  <= cfg_wdata;
                    CFG_CELLS_X: cfg_cells_reg[0] <= cfg_wdata[CNT_W-1:0];
                    CFG_CELLS_Y: cfg_cells_reg[1] <= cfg_wdata[CNT_W-1:0];
                    CFG_CELLS_Z: cfg_cells_reg[2] <= cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
        for (int i = 0; i < 3; i++) begin
            o_reg[i]   <= o_next[i];
            d_reg[i]   <= d_next[i];
            ext_reg[i] <= ext_next[i];
            p_reg[i]   <= p_next[i];
            mc_reg[i]  <= mc_next[i];
        end
        ax_reg     <= ax_next;
        inside_reg <= inside_next;
        miss_reg   <= miss_next;
        tn_reg     <= tn_next;
        tf_reg     <= tf_next;
        sa_reg     <= sa_next;
        tt_reg     <= tt_next;
        ms_reg     <= ms_next;
        mt_reg     <= mt_next;
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tuser  = ms_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 3*CELL_W - T_W){1'b0}},
                            mt_reg, mc_reg[2], mc_reg[1], mc_reg[0]};

`ifndef ASSERT_OFF
    a_no_op_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !issued_reg)
        else $error("arith op pending while idle");

    a_done_needs_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> issued_reg)
        else $error("arith done without issued op");

    a_adv_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADV && !mv_reg) |=> m_axis_tvalid)
        else $error("advance result not presented");
`endif

endmodule
